### design/aas_pkg.sv
// aas_pkg: shared types and codes of the alarm annunciator sequencer
// holds the item, result, configuration and sequence state records
// no dependencies
package aas_pkg;

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_NEW  = 2'd1;
   localparam logic [1:0] FUNC_STOP = 2'd2;
   localparam logic [1:0] FUNC_KEY  = 2'd3;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_START  = 2'd1;
   localparam logic [1:0] PH_ACTIVE = 2'd2;

   localparam logic [1:0] CSR_SHOW_TIME       = 2'd0;
   localparam logic [1:0] CSR_TOGGLE_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_MAX_GROUPS      = 2'd2;

   localparam logic [15:0] SHOW_TIME_RESET       = 16'd120;
   localparam logic [7:0]  TOGGLE_INTERVAL_RESET = 8'd1;
   localparam logic [7:0]  MAX_GROUPS_RESET      = 8'd8;

   // voice numbers that keep the previous kind, group and hint flag
   localparam logic [7:0] VOICE_KEEP_A = 8'd1;
   localparam logic [7:0] VOICE_KEEP_B = 8'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] alarm_kind;
      logic [7:0] group_no;
      logic [7:0] repeat_count;
      logic [7:0] voice_number;
      logic       has_hint;
      logic       key_pressed;
      logic       hint_continue;
   } aas_item_type;

   typedef struct packed {
      logic       buzzer_on;
      logic       led_on;
      logic       audio_valid;
      logic [7:0] audio_number;
      logic       panel_valid;
      logic [7:0] panel_group;
      logic       hint_send;
      logic [7:0] hint_kind;
      logic       alarm_busy;
      logic       voice_flag;
   } aas_result_type;

   typedef struct packed {
      logic [15:0] show_time;
      logic [7:0]  toggle_interval;
      logic [7:0]  max_groups;
   } aas_cfg_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [7:0]  voice_left;
      logic [7:0]  voice_wait;
      logic [15:0] led_wait;
      logic        buzzer_level;
      logic        led_level;
      logic        buzzer_done;
      logic        led_done;
      logic        hint_done;
      logic        key_pending;
      logic        hint_present;
      logic [7:0]  latched_kind;
      logic [7:0]  latched_group;
      logic [7:0]  latched_repeats;
      logic [7:0]  latched_voice;
      logic [7:0]  latched_interval;
      logic        voice_sticky;
   } aas_state_type;

   // drive levels and done flags come out of reset high
   localparam aas_state_type STATE_RESET = '{phase: PH_IDLE, buzzer_level: 1'b1,
                                             led_level: 1'b1, buzzer_done: 1'b1,
                                             led_done: 1'b1, hint_done: 1'b1,
                                             default: '0};

endpackage

### design/aas_core.sv
// aas_core: sequence state registers and the per-transaction update logic
// computes one result from the current state and the registered item
// depends on aas_pkg
module aas_core import aas_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  aas_item_type   item,
   input  aas_cfg_type    cfg,
   output aas_result_type result
);

   aas_state_type state_ff;
   aas_state_type state_in;

   always_comb begin
      aas_state_type  st;
      aas_result_type rs;
      st = state_ff;
      rs = '0;
      case (item.func)
         FUNC_TICK: begin
            if (st.key_pending) begin
               st.key_pending = 1'b0;
               if (st.phase != PH_IDLE) begin
                  rs.panel_valid     = 1'b1;
                  st.latched_repeats = '0;
                  st.phase           = PH_IDLE;
                  st.latched_kind    = '0;
               end
               // silence command
               rs.audio_valid = 1'b1;
            end
            case (st.phase)
               PH_IDLE: begin
                  st.buzzer_level = 1'b0;
                  st.led_level    = 1'b0;
                  st.hint_done    = 1'b1;
                  st.buzzer_done  = 1'b1;
                  st.led_done     = 1'b1;
               end
               PH_START: begin
                  if (st.hint_present) begin
                     rs.hint_send = 1'b1;
                     rs.hint_kind = st.latched_kind;
                  end
                  st.hint_done = !(st.hint_present && item.hint_continue);
                  if (st.hint_done) st.hint_present = 1'b0;
                  rs.panel_valid = 1'b1;
                  rs.panel_group = (st.latched_group < cfg.max_groups) ?
                                   st.latched_group + 8'd1 : 8'd0;
                  st.buzzer_level = 1'b1;
                  // a repeat count of zero wraps to 255 repeats
                  st.voice_left   = st.latched_repeats - 8'd1;
                  st.voice_wait   = st.latched_interval;
                  st.buzzer_done  = 1'b0;
                  st.led_level    = 1'b1;
                  st.led_done     = 1'b0;
                  st.led_wait     = cfg.show_time;
                  st.phase        = PH_ACTIVE;
               end
               PH_ACTIVE: begin
                  if (st.voice_left != 8'd0) begin
                     if (st.voice_wait == st.latched_interval) begin
                        rs.audio_valid  = 1'b1;
                        rs.audio_number = st.latched_voice;
                        st.voice_sticky = 1'b1;
                     end
                     if (st.voice_wait == 8'd0) begin
                        st.buzzer_level = !st.buzzer_level;
                        if (!st.buzzer_level) st.voice_left = st.voice_left - 8'd1;
                        st.voice_wait = st.latched_interval;
                     end else begin
                        st.voice_wait = st.voice_wait - 8'd1;
                     end
                  end else if (!st.buzzer_done) begin
                     st.buzzer_level = 1'b0;
                     st.buzzer_done  = 1'b1;
                  end
                  if (!st.hint_done) begin
                     if (st.hint_present) begin
                        rs.hint_send = 1'b1;
                        rs.hint_kind = st.latched_kind;
                     end
                     if (!(st.hint_present && item.hint_continue)) begin
                        st.hint_done    = 1'b1;
                        st.hint_present = 1'b0;
                     end
                  end
                  if (st.led_wait != 16'd0) begin
                     st.led_level = !st.led_level;
                     st.led_wait  = st.led_wait - 16'd1;
                  end else if (!st.led_done) begin
                     st.led_level = 1'b0;
                     st.led_done  = 1'b1;
                  end
                  if (st.hint_done && st.buzzer_done && st.led_done) begin
                     st.phase       = PH_IDLE;
                     rs.panel_valid = 1'b1;
                     rs.panel_group = 8'd0;
                  end
               end
               default: begin
                  st.phase = PH_IDLE;
               end
            endcase
         end
         FUNC_NEW: begin
            st.latched_voice    = item.voice_number;
            st.latched_repeats  = item.repeat_count;
            st.latched_interval = cfg.toggle_interval;
            st.phase            = PH_START;
            if (item.voice_number != VOICE_KEEP_A && item.voice_number != VOICE_KEEP_B) begin
               st.latched_kind  = item.alarm_kind;
               st.latched_group = item.group_no;
               st.hint_present  = item.has_hint;
            end
         end
         FUNC_STOP: begin
            rs.panel_valid     = 1'b1;
            st.hint_present    = 1'b0;
            st.phase           = PH_IDLE;
            st.latched_repeats = '0;
            st.latched_kind    = '0;
         end
         default: begin
            st.key_pending = item.key_pressed;
         end
      endcase
      rs.buzzer_on  = st.buzzer_level;
      rs.led_on     = st.led_level;
      rs.alarm_busy = (st.phase != PH_IDLE);
      rs.voice_flag = st.voice_sticky;
      state_in = st;
      result   = rs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

### design/alarm_annunciator_sequencer.sv
// alarm_annunciator_sequencer: top level with input and result registers
// and the configuration registers; instantiates aas_core
// depends on aas_pkg and aas_core
//
// usage: items (tick, new alarm, stop, key event) enter on the req_ stream,
// one result per item leaves on the rsp_ stream in the same order.
// configuration registers (show_time, toggle_interval, max_groups) are
// written through the csr_ channel, always ready; the user writes them
// only while the block is idle, the block itself does not enforce it.
// a taken item sits in the input register; its result is loaded into the
// result register when that is empty or being read, and is offered on rsp_.
// throughput: one item per cycle while rsp_tready is high; the sequence
// update is one pass of counter and flag logic between the two registers.
// a stalled receiver holds the result register; the input register still
// takes one more item, then req_tready drops until rsp_tready returns.
// reset (synchronous, active high) empties both registers, loads the
// configuration defaults and returns the sequence to idle with buzzer
// and led levels high until the first tick.
module alarm_annunciator_sequencer import aas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] alarm_kind, [15:8] group_no, [23:16] repeat_count,
   // [31:24] voice_number, [32] has_hint, [33] key_pressed, [34] hint_continue
   input  logic [39:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] buzzer_on, [1] led_on, [2] audio_valid, [10:3] audio_number,
   // [11] panel_valid, [19:12] panel_group, [20] hint_send, [28:21] hint_kind,
   // [29] alarm_busy, [30] voice_flag
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic           in_valid_ff;
   logic           in_valid_in;
   aas_item_type   in_item_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   aas_result_type out_result_ff;
   aas_cfg_type    cfg_ff;
   aas_cfg_type    cfg_in;
   aas_result_type step_result;
   logic           advance;
   logic           req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SHOW_TIME:       cfg_in.show_time       = csr_data;
            CSR_TOGGLE_INTERVAL: cfg_in.toggle_interval = csr_data[7:0];
            CSR_MAX_GROUPS:      cfg_in.max_groups      = csr_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '{SHOW_TIME_RESET, TOGGLE_INTERVAL_RESET, MAX_GROUPS_RESET};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         // func, kind, group, repeats, voice, hint, key, continue
         in_item_ff <= {req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[23:16],
                        req_tdata[31:24], req_tdata[32], req_tdata[33], req_tdata[34]};
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   aas_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0,
                        out_result_ff.voice_flag,
                        out_result_ff.alarm_busy,
                        out_result_ff.hint_kind,
                        out_result_ff.hint_send,
                        out_result_ff.panel_group,
                        out_result_ff.panel_valid,
                        out_result_ff.audio_number,
                        out_result_ff.audio_valid,
                        out_result_ff.led_on,
                        out_result_ff.buzzer_on};

endmodule
